// ===== hdl/rcpb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the rounded-corner pixel blend core.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package rcpb_pkg;

	// Field widths
	localparam int PIX_W   = 32;
	localparam int POS_W   = 12;
	localparam int DIM_W   = 13;
	localparam int RAD_W   = 11;
	localparam int ROOT_W  = 16;
	localparam int SQRT_STEPS = 16;

	// Largest surface edge; larger register values clamp to this
	localparam logic [DIM_W-1:0] MAX_SURFACE_DIM = 13'd4096;

	// Top bit of the square-root trial walk
	localparam logic [31:0] ROOT_TOP_BIT = 32'h4000_0000;

	localparam logic [7:0]  COV_FULL     = 8'hFF;
	localparam logic [7:0]  COV_NONE     = 8'h00;
	localparam logic [31:0] ALPHA_MASK   = 32'hFF00_0000;
	localparam logic [15:0] MUL8_BIAS    = 16'd128;

	// Configuration register indexes
	typedef enum logic [7:0] {
		CFG_BLEND_MODE     = 8'd0,
		CFG_OPACITY        = 8'd1,
		CFG_SURFACE_WIDTH  = 8'd2,
		CFG_SURFACE_HEIGHT = 8'd3,
		CFG_CORNER_RADIUS  = 8'd4
	} cfg_idx_t;

	// Register file as seen by the datapath
	typedef struct packed {
		logic             blend_mode;
		logic [7:0]       opacity;
		logic [DIM_W-1:0] surface_w;
		logic [DIM_W-1:0] surface_h;
		logic [RAD_W-1:0] radius;
	} cfg_t;

	// Coverage classification of one pixel position
	typedef struct packed {
		logic outside;
		logic rzero;
		logic corner;
	} cov_flags_t;

	// Payload that rides alongside the geometry and root stages
	typedef struct packed {
		logic [PIX_W-1:0] src;
		logic [PIX_W-1:0] dst;
		cov_flags_t       flg;
	} pix_side_t;

	// First half of the rounding divide by 255: a*b + 128
	function automatic logic [15:0] mul8_prod(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] p;
		p = {8'h00, a} * {8'h00, b};
		return p + MUL8_BIAS;
	endfunction

	// Second half of the rounding divide by 255: (t + (t >> 8)) >> 8
	function automatic logic [7:0] mul8_fin(input logic [15:0] t);
		logic [15:0] s;
		s = t + {8'h00, t[15:8]};
		return s[15:8];
	endfunction

endpackage

// ===== hdl/rcpb_geom.sv =====
`timescale 1ns / 1ps
// Corner geometry front end: classifies the position and forms the squared
// distance to the corner circle centre in 1/256 pixel^2. Depends on rcpb_pkg.

module rcpb_geom (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rcpb_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rcpb_pkg::PIX_W-1:0]        src_pixel,
	input  logic [rcpb_pkg::PIX_W-1:0]        dst_pixel,
	input  logic [rcpb_pkg::POS_W-1:0]        local_x,
	input  logic [rcpb_pkg::POS_W-1:0]        local_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       out_rad2,
	output rcpb_pkg::pix_side_t               out_side
);

	logic [rcpb_pkg::DIM_W-1:0] w, h, x13, y13, r13;
	logic [rcpb_pkg::DIM_W-1:0] dx13, dy13;
	logic                       left, right, top, bot;
	rcpb_pkg::cov_flags_t       flg;

	logic                       v_s1, v_s2, v_s3;
	logic                       adv1, adv2, adv3;
	logic [rcpb_pkg::RAD_W-1:0] dx_s1, dy_s1;
	logic [2*rcpb_pkg::RAD_W-1:0] sqx_s2, sqy_s2;
	logic [2*rcpb_pkg::RAD_W:0] sum_s3;
	rcpb_pkg::pix_side_t        side_s1, side_s2, side_s3;

	// Clamp the surface and classify the position
	always_comb begin
		w = (cfg.surface_w > rcpb_pkg::MAX_SURFACE_DIM) ? rcpb_pkg::MAX_SURFACE_DIM : cfg.surface_w;
		h = (cfg.surface_h > rcpb_pkg::MAX_SURFACE_DIM) ? rcpb_pkg::MAX_SURFACE_DIM : cfg.surface_h;
		x13 = {1'b0, local_x};
		y13 = {1'b0, local_y};
		r13 = {2'b00, cfg.radius};
		left  = x13 < r13;
		right = (x13 + r13) >= w;
		top   = y13 < r13;
		bot   = (y13 + r13) >= h;
		flg.outside = (x13 >= w) || (y13 >= h);
		flg.rzero   = (cfg.radius == '0);
		flg.corner  = (left || right) && (top || bot);
		// Offset to the corner centre in whole pixels; left and top corners win
		dx13 = left ? (r13 - 13'd1 - x13) : (x13 + r13 - w);
		dy13 = top  ? (r13 - 13'd1 - y13) : (y13 + r13 - h);
	end

	// Advance a stage when it is empty or its successor moves
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Offsets, squares, sum
	always_ff @(posedge clk) begin
		if (adv1) begin
			dx_s1   <= dx13[rcpb_pkg::RAD_W-1:0];
			dy_s1   <= dy13[rcpb_pkg::RAD_W-1:0];
			side_s1 <= '{src: src_pixel, dst: dst_pixel, flg: flg};
		end
		if (adv2) begin
			sqx_s2  <= dx_s1 * dx_s1;
			sqy_s2  <= dy_s1 * dy_s1;
			side_s2 <= side_s1;
		end
		if (adv3) begin
			sum_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			side_s3 <= side_s2;
		end
	end

	// Shift the sum of whole-pixel squares by 256 so the root comes out in 1/16 pixel
	assign out_valid = v_s3;
	assign out_rad2  = {1'b0, sum_s3, 8'h00};
	assign out_side  = side_s3;

endmodule

// ===== hdl/rcpb_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root: one restoring trial step per register stage.
// Carries the pixel payload alongside. Depends on rcpb_pkg.

module rcpb_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   in_rad2,
	input  rcpb_pkg::pix_side_t           in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rcpb_pkg::ROOT_W-1:0]   out_root,
	output rcpb_pkg::pix_side_t           out_side
);

	localparam int N = rcpb_pkg::SQRT_STEPS;

	logic [31:0]         rem_s  [1:N];
	logic [31:0]         res_s  [1:N];
	rcpb_pkg::pix_side_t side_s [1:N];
	logic [N:1]          vld_s;
	logic [N:1]          adv;

	// One trial: subtract res+bit when it fits and shift the partial root
	function automatic logic [63:0] root_step(input logic [31:0] rem, input logic [31:0] res,
		input int k);
		logic [31:0] bitv, trial;
		bitv  = rcpb_pkg::ROOT_TOP_BIT >> (2 * k);
		trial = res + bitv;
		if (rem >= trial) return {rem - trial, (res >> 1) + bitv};
		return {rem, res >> 1};
	endfunction

	// Ready chain from the output back to the input
	always_comb begin
		adv[N] = !vld_s[N] || out_ready;
		for (int k = N - 1; k >= 1; k--) adv[k] = !vld_s[k] || adv[k+1];
	end
	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= N; k++) begin
				if (adv[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Step k of the root lives between register k-1 and register k
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			{rem_s[1], res_s[1]} <= root_step(in_rad2, 32'd0, 0);
			side_s[1] <= in_side;
		end
		for (int k = 2; k <= N; k++) begin
			if (adv[k]) begin
				{rem_s[k], res_s[k]} <= root_step(rem_s[k-1], res_s[k-1], k - 1);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = res_s[N][rcpb_pkg::ROOT_W-1:0];
	assign out_side  = side_s[N];

endmodule

// ===== hdl/rcpb_blend.sv =====
`timescale 1ns / 1ps
// Coverage ramp, effective alpha and per-channel blend with the output register.
// Depends on rcpb_pkg; fed by rcpb_sqrt.

module rcpb_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcpb_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rcpb_pkg::ROOT_W-1:0]   in_root,
	input  rcpb_pkg::pix_side_t           in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rcpb_pkg::PIX_W-1:0]    out_pixel,
	output logic                          write_enable,
	output logic [7:0]                    coverage
);

	logic [16:0] r16e, de, num17;
	logic [3:0]  num;
	logic [11:0] ramp12;
	logic [12:0] ramp13;
	logic        full_in, beyond;
	logic [7:0]  cov_c, a1_c;
	logic [8:0]  ch_sum [0:2];
	logic [31:0] mix_c;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        adv1, adv2, adv3, adv4, adv5;
	logic [7:0]  cov_s1, cov_s2, cov_s3, cov_s4;
	logic [15:0] ta_s1, tb_s2;
	logic [7:0]  alpha_s3, alpha_s4;
	logic [15:0] ts_s4 [0:2];
	logic [15:0] td_s4 [0:2];
	logic [31:0] src_s1, src_s2, src_s3, src_s4;
	logic [31:0] dst_s1, dst_s2, dst_s3, dst_s4;
	logic [31:0] pix_s5;
	logic        we_s5;
	logic [7:0]  cov_s5;

	// Coverage: linear ramp across one pixel centred on the radius
	always_comb begin
		r16e   = {2'b00, cfg.radius, 4'h0};
		de     = {1'b0, in_root};
		full_in = (de + 17'd8) <= r16e;
		beyond  = de >= (r16e + 17'd8);
		num17  = r16e + 17'd8 - de;
		num    = num17[3:0];
		ramp12 = {num, 8'h00} - {8'h00, num};
		ramp13 = {1'b0, ramp12} + 13'd8;
		if (in_side.flg.outside)     cov_c = rcpb_pkg::COV_NONE;
		else if (in_side.flg.rzero)  cov_c = rcpb_pkg::COV_FULL;
		else if (!in_side.flg.corner) cov_c = rcpb_pkg::COV_FULL;
		else if (full_in)            cov_c = rcpb_pkg::COV_FULL;
		else if (beyond)             cov_c = rcpb_pkg::COV_NONE;
		else                         cov_c = ramp13[11:4];
	end

	assign a1_c = rcpb_pkg::mul8_fin(ta_s1);

	// Final channel sums with saturation
	always_comb begin
		mix_c = rcpb_pkg::ALPHA_MASK;
		for (int c = 0; c < 3; c++) begin
			ch_sum[c] = {1'b0, rcpb_pkg::mul8_fin(ts_s4[c])} + {1'b0, rcpb_pkg::mul8_fin(td_s4[c])};
			mix_c[8*c +: 8] = ch_sum[c][8] ? 8'hFF : ch_sum[c][7:0];
		end
	end

	// Ready chain
	assign adv5     = !v_s5 || out_ready;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// Coverage; source alpha times global alpha
		if (adv1) begin
			cov_s1 <= cov_c;
			ta_s1  <= rcpb_pkg::mul8_prod(in_side.src[31:24], cfg.opacity);
			src_s1 <= in_side.src;
			dst_s1 <= in_side.dst;
		end
		// Scale by coverage
		if (adv2) begin
			cov_s2 <= cov_s1;
			tb_s2  <= rcpb_pkg::mul8_prod(a1_c, cov_s1);
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
		end
		// Pick the effective alpha for the mode
		if (adv3) begin
			cov_s3   <= cov_s2;
			alpha_s3 <= cfg.blend_mode ? rcpb_pkg::mul8_fin(tb_s2) : cov_s2;
			src_s3   <= src_s2;
			dst_s3   <= dst_s2;
		end
		// Channel products
		if (adv4) begin
			cov_s4   <= cov_s3;
			alpha_s4 <= alpha_s3;
			src_s4   <= src_s3;
			dst_s4   <= dst_s3;
			for (int c = 0; c < 3; c++) begin
				ts_s4[c] <= rcpb_pkg::mul8_prod(src_s3[8*c +: 8], alpha_s3);
				td_s4[c] <= rcpb_pkg::mul8_prod(dst_s3[8*c +: 8], ~alpha_s3);
			end
		end
		// Output register: keep, copy opaque, or blend
		if (adv5) begin
			cov_s5 <= cov_s4;
			if (alpha_s4 == rcpb_pkg::COV_FULL) begin
				pix_s5 <= src_s4 | rcpb_pkg::ALPHA_MASK;
				we_s5  <= 1'b1;
			end else if (alpha_s4 == rcpb_pkg::COV_NONE) begin
				pix_s5 <= dst_s4;
				we_s5  <= 1'b0;
			end else begin
				pix_s5 <= mix_c;
				we_s5  <= 1'b1;
			end
		end
	end

	assign out_valid    = v_s5;
	assign out_pixel    = pix_s5;
	assign write_enable = we_s5;
	assign coverage     = cov_s5;

endmodule

// ===== hdl/rounded_corner_pixel_blend_core.sv =====
`timescale 1ns / 1ps
// Top level of the rounded-corner ARGB8888 blend core: configuration registers
// and the geometry, square-root and blend pipelines. Depends on rcpb_pkg and rcpb_*.

// Usage
//   Input stream s_*: one beat per pixel carrying source, destination and the
//   pixel position in the source surface. Output stream m_*: one beat per input
//   beat, in order, carrying the new destination pixel and coverage, with the
//   write enable in m_tuser.
//   Config channel cfg_*: always ready; writes blend mode, global alpha, surface
//   width and height and corner radius. Write only while the pipeline is empty.
//   Pipeline: 3 geometry stages, 16 square-root stages of one trial each and 5
//   blend stages. Throughput: one pixel per clock while the output is not
//   stalled; the 16-step root is fully unrolled into stages.
//   Reset (arst_n low) empties the pipeline and loads mode 0, global alpha 255,
//   surface 4096 x 4096 and radius 0.
//   When m_tready is low, the output beat holds and stages behind it keep filling
//   empty slots; s_tready drops only once all 24 stages hold a pixel.

module rounded_corner_pixel_blend_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,    // src_pixel[31:0], dst_pixel[63:32], local_x[75:64], local_y[87:76]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // out_pixel[31:0], coverage[39:32]
	output logic [0:0]  m_tuser,    // write_enable[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                             blend_mode_q;
	logic [7:0]                       opacity_q;
	logic [rcpb_pkg::DIM_W-1:0]       surface_w_q, surface_h_q;
	logic [rcpb_pkg::RAD_W-1:0]       radius_q;
	rcpb_pkg::cfg_t                   cfg;

	logic                             g_valid, g_ready, r_valid, r_ready;
	logic [31:0]                      g_rad2;
	rcpb_pkg::pix_side_t              g_side, r_side;
	logic [rcpb_pkg::ROOT_W-1:0]      r_root;
	logic [rcpb_pkg::PIX_W-1:0]       out_pixel;
	logic                             write_enable;
	logic [7:0]                       coverage;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q   <= 1'b0;
			opacity_q      <= 8'hFF;
			surface_w_q    <= rcpb_pkg::MAX_SURFACE_DIM;
			surface_h_q    <= rcpb_pkg::MAX_SURFACE_DIM;
			radius_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcpb_pkg::CFG_BLEND_MODE:     blend_mode_q   <= cfg_data[0];
				rcpb_pkg::CFG_OPACITY:        opacity_q      <= cfg_data[7:0];
				rcpb_pkg::CFG_SURFACE_WIDTH:  surface_w_q    <= cfg_data[rcpb_pkg::DIM_W-1:0];
				rcpb_pkg::CFG_SURFACE_HEIGHT: surface_h_q    <= cfg_data[rcpb_pkg::DIM_W-1:0];
				rcpb_pkg::CFG_CORNER_RADIUS:  radius_q       <= cfg_data[rcpb_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{blend_mode: blend_mode_q, opacity: opacity_q,
		surface_w: surface_w_q, surface_h: surface_h_q, radius: radius_q};

	rcpb_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.src_pixel (s_tdata[31:0]),
		.dst_pixel (s_tdata[63:32]),
		.local_x   (s_tdata[75:64]),
		.local_y   (s_tdata[87:76]),
		.out_valid (g_valid),
		.out_ready (g_ready),
		.out_rad2  (g_rad2),
		.out_side  (g_side)
	);

	rcpb_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (g_valid),
		.in_ready  (g_ready),
		.in_rad2   (g_rad2),
		.in_side   (g_side),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_root  (r_root),
		.out_side  (r_side)
	);

	rcpb_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (r_valid),
		.in_ready     (r_ready),
		.in_root      (r_root),
		.in_side      (r_side),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_pixel    (out_pixel),
		.write_enable (write_enable),
		.coverage     (coverage)
	);

	assign m_tdata = {coverage, out_pixel};
	assign m_tuser = write_enable;

`ifndef SYNTHESIS
	// Zero coverage never writes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[39:32] == rcpb_pkg::COV_NONE) |-> !m_tuser[0])
		else $error("write with zero coverage");

	// Every written pixel is opaque
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[31:24] == 8'hFF))
		else $error("written pixel not opaque");

	// Copy mode with full coverage always writes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !blend_mode_q && (m_tdata[39:32] == rcpb_pkg::COV_FULL) |-> m_tuser[0])
		else $error("full coverage in copy mode did not write");

	// Input backpressure only comes from a stalled output beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output is free");
`endif

endmodule

// ===== tb/rounded_corner_pixel_blend_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rounded_corner_pixel_blend_core: directed clipping, corner and
// alpha cases, then randomized register settings and pixels scored against a behavioral model.
// Depends on rcpb_pkg and the core RTL only.

module rounded_corner_pixel_blend_core_tb;
	import rcpb_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 32;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_ITEMS = 125;
	localparam int DIR_PHASES    = 7;
	localparam logic [7:0] FIRST_UNUSED_IDX = 8'd5;

	// Input beat, laid out exactly as s_tdata: src lowest, local_y highest
	typedef struct packed {
		logic [11:0] y;
		logic [11:0] x;
		logic [31:0] dst;
		logic [31:0] src;
	} pixel_beat_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        wr_en;
		logic [7:0]  cov;
	} blend_result_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  ga;
		logic [12:0] w;
		logic [12:0] h;
		logic [10:0] r;
	} settings_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic [15:0] val;
	} reg_write_t;

	typedef struct {
		int            phase;
		pixel_beat_t   beat;
		bit            typed;
		blend_result_t want;
	} dir_row_t;

	typedef struct {
		int            seq;
		blend_result_t res;
	} typed_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;      // src_pixel, dst_pixel, local_x, local_y
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;           // out_pixel, coverage
	logic [0:0]  m_tuser;           // write_enable
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Register mirror, loaded with the reset values
	logic        cur_mode = 1'b0;
	logic [7:0]  cur_alpha = 8'd255;
	logic [12:0] cur_width = 13'd4096;
	logic [12:0] cur_height = 13'd4096;
	logic [10:0] cur_radius = 11'd0;

	blend_result_t blend_expected [$];
	typed_exp_t    typed_q [$];
	dir_row_t      directed_rows [$];

	int n_issued = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_settings = 1;
	int quiet_cycles = 0;
	int hold_len = 0;
	int gap_ceiling = 0;
	int burst_left = 1;

	always #1 clk = ~clk;

	rounded_corner_pixel_blend_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Rounding multiply-and-divide by 255
	function automatic int unsigned div255_round(input int unsigned a, input int unsigned b);
		int unsigned t;
		t = a * b + 128;
		return (t + (t >> 8)) >> 8;
	endfunction

	// Bit-pair integer square root
	function automatic logic [15:0] isqrt32(input logic [31:0] v);
		logic [31:0] rem, root, probe, trial;
		rem = v;
		root = '0;
		probe = 32'h4000_0000;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			trial = root + probe;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[15:0];
	endfunction

	// Rounded-rectangle coverage of one position under the mirrored registers
	function automatic int unsigned corner_coverage(input int x, input int y);
		int w, h, r, cx, cy, ex, ey;
		int unsigned radial, r16, ramp;
		bit near_l, near_r, near_t, near_b;
		w = (cur_width > MAX_SURFACE_DIM) ? int'(MAX_SURFACE_DIM) : int'(cur_width);
		h = (cur_height > MAX_SURFACE_DIM) ? int'(MAX_SURFACE_DIM) : int'(cur_height);
		r = int'(cur_radius);
		if (x >= w || y >= h)
			return 0;
		if (r == 0)
			return 255;
		near_l = x < r;
		near_r = x >= w - r;
		near_t = y < r;
		near_b = y >= h - r;
		if (!((near_l || near_r) && (near_t || near_b)))
			return 255;
		// left and top centers win when the radius overruns half the surface
		cx = near_l ? (2 * r - 1) * 8 : (2 * (w - r) + 1) * 8;
		cy = near_t ? (2 * r - 1) * 8 : (2 * (h - r) + 1) * 8;
		ex = x * 16 + 8 - cx;
		ey = y * 16 + 8 - cy;
		radial = isqrt32(32'(longint'(ex) * ex + longint'(ey) * ey));
		r16 = r * 16;
		if (radial + 8 <= r16)
			return 255;
		if (radial >= r16 + 8)
			return 0;
		ramp = ((r16 + 8 - radial) * 255 + 8) / 16;
		return (ramp > 255) ? 255 : ramp;
	endfunction

	function automatic blend_result_t predict_blend(input pixel_beat_t b);
		int unsigned cov, a, ch;
		blend_result_t res;
		cov = corner_coverage(int'(b.x), int'(b.y));
		a = cur_mode ? div255_round(div255_round(b.src[31:24], cur_alpha), cov) : cov;
		res.cov = 8'(cov);
		res.pixel = b.dst;
		res.wr_en = 1'b0;
		if (a == 255) begin
			res.pixel = b.src | ALPHA_MASK;
			res.wr_en = 1'b1;
		end else if (a != 0) begin
			res.pixel = ALPHA_MASK;
			for (int sh = 0; sh <= 16; sh += 8) begin
				ch = div255_round((b.src >> sh) & 32'hFF, a)
					+ div255_round((b.dst >> sh) & 32'hFF, 255 - a);
				if (ch > 255)
					ch = 255;
				res.pixel = res.pixel | (ch << sh);
			end
			res.wr_en = 1'b1;
		end
		return res;
	endfunction

	// Track register writes, score output beats, predict accepted input beats
	always @(posedge clk) begin : scoreboard
		blend_result_t want;
		typed_exp_t    typed_row;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BLEND_MODE:     cur_mode = cfg_data[0];
					CFG_OPACITY:        cur_alpha = cfg_data[7:0];
					CFG_SURFACE_WIDTH:  cur_width = cfg_data[12:0];
					CFG_SURFACE_HEIGHT: cur_height = cfg_data[12:0];
					CFG_CORNER_RADIUS:  cur_radius = cfg_data[10:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (blend_expected.size() == 0) begin
					$error("output beat with no pixel outstanding: out_pixel %h", m_tdata[31:0]);
					n_errors++;
				end else begin
					want = blend_expected.pop_front();
					if (typed_q.size() != 0 && typed_q[0].seq == n_checked) begin
						typed_row = typed_q.pop_front();
						want = typed_row.res;
					end
					if (m_tdata[31:0] !== want.pixel) begin
						$error("out_pixel: expected %h, got %h", want.pixel, m_tdata[31:0]);
						n_errors++;
					end
					if (m_tuser[0] !== want.wr_en) begin
						$error("write_enable: expected %b, got %b", want.wr_en, m_tuser[0]);
						n_errors++;
					end
					if (m_tdata[39:32] !== want.cov) begin
						$error("coverage: expected %0d, got %0d", want.cov, m_tdata[39:32]);
						n_errors++;
					end
				end
				n_checked++;
			end
			if (s_tvalid && s_tready)
				blend_expected.push_back(predict_blend(s_tdata));
		end
	end

	// Abort when no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Output back-pressure: rotating ready pattern, or a long hold-off on request
	initial begin : receiver
		logic [15:0] rdy_pattern;
		int step;
		rdy_pattern = '1;
		step = 0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				if (step == 0) begin
					case ($urandom_range(0, 3))
						0: rdy_pattern = '1;
						1: rdy_pattern = 16'($urandom);
						2: rdy_pattern = 16'($urandom & $urandom);
						default: rdy_pattern = 16'($urandom | $urandom);
					endcase
				end
				step = (step + 1) % 16;
				m_tready <= rdy_pattern[step];
			end
		end
	end

	// Offer one pixel, hold it until taken, then maybe idle after the burst
	task automatic send_pixel(input pixel_beat_t b);
		int gap;
		s_tdata <= b;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		n_issued++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_ceiling > 0) ? $urandom_range(0, gap_ceiling) : 0;
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every outstanding pixel has come back
	task automatic finish_phase();
		s_tvalid <= 1'b0;
		wait (n_checked == n_issued);
		@(posedge clk);
	endtask

	// Write all five registers; with noise, set unused data bits and poke an unused index
	task automatic apply_settings(input settings_t cfg, input bit noisy);
		reg_write_t wr_q [$];
		logic [15:0] junk [5];
		foreach (junk[i])
			junk[i] = noisy ? 16'($urandom) : 16'h0000;
		if (noisy)
			wr_q.push_back('{8'($urandom_range(FIRST_UNUSED_IDX, 255)), 16'($urandom)});
		wr_q.push_back('{CFG_BLEND_MODE, (junk[0] & 16'hFFFE) | 16'(cfg.mode)});
		wr_q.push_back('{CFG_OPACITY, (junk[1] & 16'hFF00) | 16'(cfg.ga)});
		wr_q.push_back('{CFG_SURFACE_WIDTH, (junk[2] & 16'hE000) | 16'(cfg.w)});
		wr_q.push_back('{CFG_SURFACE_HEIGHT, (junk[3] & 16'hE000) | 16'(cfg.h)});
		wr_q.push_back('{CFG_CORNER_RADIUS, (junk[4] & 16'hF800) | 16'(cfg.r)});
		foreach (wr_q[i]) begin
			cfg_index <= wr_q[i].idx;
			cfg_data <= wr_q[i].val;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic void add_row(input int phase, input logic [31:0] src,
			input logic [31:0] dst, input logic [11:0] x, input logic [11:0] y,
			input bit typed = 1'b0, input logic [31:0] pix = '0,
			input logic we = 1'b0, input logic [7:0] cov = '0);
		dir_row_t row;
		row.phase = phase;
		row.beat = '{y, x, dst, src};
		row.typed = typed;
		row.want = '{pix, we, cov};
		directed_rows.push_back(row);
	endfunction

	function automatic logic [12:0] random_dim();
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return MAX_SURFACE_DIM;
			2: return 13'($urandom_range(4097, 8191));
			3: return 13'($urandom_range(1, 4095));
			default: return 13'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic settings_t random_settings();
		settings_t s;
		int lim;
		s.mode = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: s.ga = 8'd0;
			1: s.ga = 8'd255;
			default: s.ga = 8'($urandom);
		endcase
		s.w = random_dim();
		s.h = random_dim();
		lim = ((s.w < s.h) ? s.w : s.h);
		if (lim > 4096)
			lim = 4096;
		lim = lim / 2 + 2;
		case ($urandom_range(0, 7))
			0: s.r = 11'd0;
			1: s.r = 11'd2047;
			2: s.r = 11'($urandom);
			default: s.r = 11'($urandom_range(1, (lim > 2047) ? 2047 : lim));
		endcase
		return s;
	endfunction

	// Half the time near the rounded edges, some inside, some just past the surface, some anywhere
	function automatic logic [11:0] pick_coord(input int n, input int r);
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				v = $urandom_range(0, r + 1);
				if ($urandom_range(0, 1))
					v = n - 1 - v;
			end
			5, 6, 7: v = (n > 0) ? $urandom_range(0, n - 1) : 0;
			8: v = n + $urandom_range(0, 3);
			default: v = $urandom_range(0, 4095);
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	function automatic pixel_beat_t random_pixel(input settings_t s);
		pixel_beat_t b;
		int w, h;
		w = (s.w > MAX_SURFACE_DIM) ? int'(MAX_SURFACE_DIM) : int'(s.w);
		h = (s.h > MAX_SURFACE_DIM) ? int'(MAX_SURFACE_DIM) : int'(s.h);
		b.src = $urandom;
		b.dst = $urandom;
		case ($urandom_range(0, 7))
			0, 1: b.src[31:24] = 8'hFF;
			2: b.src[31:24] = 8'h00;
			default: ;
		endcase
		b.x = pick_coord(w, int'(s.r));
		b.y = pick_coord(h, int'(s.r));
		return b;
	endfunction

	initial begin : stimulus
		settings_t dir_cfg [DIR_PHASES];
		settings_t seg;

		// Directed settings; phase 0 runs on reset values
		dir_cfg[0] = '{1'b0, 8'd255, 13'd4096, 13'd4096, 11'd0};
		dir_cfg[1] = '{1'b1, 8'd128, 13'd100, 13'd50, 11'd10};
		dir_cfg[2] = '{1'b1, 8'd0, 13'd4096, 13'd4096, 11'd0};
		dir_cfg[3] = '{1'b0, 8'd255, 13'd0, 13'd8191, 11'd2047};
		dir_cfg[4] = '{1'b0, 8'd255, 13'd3, 13'd8191, 11'd2047};
		dir_cfg[5] = '{1'b0, 8'd255, 13'd8191, 13'd8191, 11'd0};
		dir_cfg[6] = '{1'b1, 8'd200, 13'd4096, 13'd4096, 11'd2047};

		// Reset registers: full coverage everywhere, opaque copy
		add_row(0, 32'h1234_5678, 32'hDEAD_BEEF, 12'd0, 12'd0, 1, 32'hFF34_5678, 1, 8'hFF);
		add_row(0, 32'h00AB_CDEF, 32'h1111_1111, 12'd4095, 12'd4095, 1, 32'hFFAB_CDEF, 1, 8'hFF);
		add_row(0, 32'hFFFF_FFFF, 32'h0000_0000, 12'd4095, 12'd0, 1, 32'hFFFF_FFFF, 1, 8'hFF);
		add_row(0, 32'h8040_2010, 32'h0102_0304, 12'd0, 12'd4095, 1, 32'hFF40_2010, 1, 8'hFF);
		// Small surface: clipped positions, zero source alpha, corner ramp
		add_row(1, 32'hFF00_FF00, 32'h0F0F_0F0F, 12'd100, 12'd0, 1, 32'h0F0F_0F0F, 0, 8'h00);
		add_row(1, 32'hFFFF_FFFF, 32'hCAFE_F00D, 12'd0, 12'd50, 1, 32'hCAFE_F00D, 0, 8'h00);
		add_row(1, 32'h00FF_FFFF, 32'hAABB_CCDD, 12'd50, 12'd25, 1, 32'hAABB_CCDD, 0, 8'hFF);
		add_row(1, 32'hFF80_8080, 32'h0040_4040, 12'd50, 12'd25);
		add_row(1, 32'hFFFF_FFFF, 32'h0000_0000, 12'd0, 12'd0);
		add_row(1, 32'hFFFF_FFFF, 32'h0000_0000, 12'd3, 12'd3);
		add_row(1, 32'hC0FF_FFFF, 32'h0000_0000, 12'd96, 12'd47);
		add_row(1, 32'hFF12_3456, 32'h00FE_DCBA, 12'd99, 12'd49);
		// Zero global alpha keeps the destination
		add_row(2, 32'hFFFF_FFFF, 32'h1234_5678, 12'd7, 12'd7, 1, 32'h1234_5678, 0, 8'hFF);
		add_row(2, 32'hFF00_0000, 32'h8765_4321, 12'd4095, 12'd4095, 1, 32'h8765_4321, 0, 8'hFF);
		// Zero width: everything outside
		add_row(3, 32'hFFFF_FFFF, 32'h55AA_55AA, 12'd0, 12'd0, 1, 32'h55AA_55AA, 0, 8'h00);
		// Radius past half the surface, oversized height
		add_row(4, 32'hFFFF_FFFF, 32'h0000_0000, 12'd0, 12'd0);
		add_row(4, 32'hFF80_FF80, 32'h0000_0000, 12'd2, 12'd4095);
		add_row(4, 32'hFF01_0203, 32'hFFFF_FFFF, 12'd1, 12'd2000);
		add_row(4, 32'hFFFF_0000, 32'h00FF_00FF, 12'd2, 12'd4094);
		// Oversized width and height saturate to the maximum surface
		add_row(5, 32'h0102_0304, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 1, 32'hFF02_0304, 1, 8'hFF);
		// Largest radius on the full surface with a partial global alpha
		add_row(6, 32'hFFFF_FFFF, 32'h0000_0000, 12'd0, 12'd0);
		add_row(6, 32'hFFFF_FFFF, 32'h0000_0000, 12'd2047, 12'd2047);
		add_row(6, 32'h80A0_B0C0, 32'h4050_6070, 12'd4095, 12'd0);
		add_row(6, 32'hFF33_6699, 32'h99CC_FF00, 12'd600, 12'd100);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part
		gap_ceiling = 3;
		for (int p = 0; p < DIR_PHASES; p++) begin
			if (p != 0)
				apply_settings(dir_cfg[p], p == 2);
			foreach (directed_rows[i]) begin
				if (directed_rows[i].phase == p) begin
					if (directed_rows[i].typed)
						typed_q.push_back('{n_issued, directed_rows[i].want});
					send_pixel(directed_rows[i].beat);
				end
			end
			finish_phase();
		end

		// Random part; the first segment fills the pipe behind a long output hold-off
		for (int s = 0; s < SEGMENTS; s++) begin
			seg = random_settings();
			apply_settings(seg, 1'b1);
			gap_ceiling = (s == 0) ? 0 : $urandom_range(0, 10);
			if (s == 0)
				hold_len = HOLD_CYCLES;
			for (int i = 0; i < SEGMENT_ITEMS; i++) begin
				if (s == 3 && i == SEGMENT_ITEMS / 2)
					finish_phase();
				send_pixel(random_pixel(seg));
			end
			finish_phase();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (blend_expected.size() != 0) begin
			$error("%0d expected pixels never came out", blend_expected.size());
			n_errors++;
		end
		$display("Summary: %0d pixels scored under %0d register settings, %0d mismatches",
			n_checked, n_settings, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rcpb_pkg.sv
hdl/rcpb_geom.sv
hdl/rcpb_sqrt.sv
hdl/rcpb_blend.sv
hdl/rounded_corner_pixel_blend_core.sv
tb/rounded_corner_pixel_blend_core_tb.sv
